FILE: sv/cbc_pkg.sv
package cbc_pkg;

	// bus transaction kinds
	localparam logic [1:0] OP_CTRL_WR = 2'd0;
	localparam logic [1:0] OP_RAM_WR  = 2'd1;
	localparam logic [1:0] OP_RAM_RD  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_MAPPER_MODE   = 2'd0;
	localparam logic [1:0] CFG_ROM_BANK_MASK = 2'd1;
	localparam logic [1:0] CFG_RAM_BANK_MASK = 2'd2;

	// control write regions, address bits 15..13
	localparam logic [2:0] RGN_RAM_ENABLE = 3'd0;
	localparam logic [2:0] RGN_BANK_LO    = 3'd1;
	localparam logic [2:0] RGN_BANK_HI    = 3'd2;
	localparam logic [2:0] RGN_MODE_SEL   = 3'd3;

	// read data source for the result
	localparam logic [1:0] RD_ZERO = 2'd0;
	localparam logic [1:0] RD_OFF  = 2'd1;
	localparam logic [1:0] RD_MEM  = 2'd2;

	localparam int unsigned RAM_BANK_BYTES = 8192;
	localparam int unsigned RAM_OFS_W      = 13;

	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
	localparam logic [7:0] RAM_OFF_BYTE   = 8'hFF;
	localparam logic [6:0] ROM_BANK_RESET = 7'd1;

	// effective banks and enable after a transaction
	typedef struct packed {
		logic [6:0] rom_bank;
		logic [2:0] ram_bank;
		logic       ram_on;
	} bank_view_t;

	// memory access command
	typedef struct packed {
		logic wr;
		logic rd;
	} ram_cmd_t;

endpackage

FILE: sv/cartridge_bank_controller_core.sv
// cartridge bank controller core
// input channel (in_valid/in_stall) carries one bus transaction: a control
// write below 0x8000, an external ram write or an external ram read. the
// output channel (out_valid/out_stall) returns one result per transaction:
// read_data plus the effective rom bank, ram bank and ram enable after it.
// configuration (mapper_mode, rom_bank_mask, ram_bank_mask) is written
// through cfg_we/cfg_index/cfg_data; the user must do so only while no
// transaction is in flight, which the block itself does not enforce.
// the pipe is one input register, then the bank update and the single
// ram port access, whose read data and the result register form the
// output stage. one transaction is accepted per cycle while in_stall is low.
// a stalled result holds in the output stage while one more transaction
// may wait in the input register; in_stall rises only when both are full
// or while the ram is cleared after reset, one byte per cycle, all
// MEM_BANK_COUNT * 8192 bytes (32768 by default).
// reset sets rom bank 1, ram bank 0, ram disabled and the split mode.
module cartridge_bank_controller_core
	import cbc_pkg::*;
#(
	parameter int unsigned MEM_BANK_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic [6:0]  rom_bank,
	output logic [2:0]  ram_bank,
	output logic        ram_on
);

	localparam int unsigned RAM_DEPTH = MEM_BANK_COUNT * RAM_BANK_BYTES;
	localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

	logic       mapper_mode_q;
	logic [6:0] rom_bank_mask_q;
	logic [2:0] ram_bank_mask_q;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	logic       valid_s2;
	logic [6:0] rom_bank_s2;
	logic [2:0] ram_bank_s2;
	logic       ram_on_s2;
	logic [1:0] rd_sel_s2;

	logic              advance;
	logic              accept;
	logic              clearing;
	bank_view_t        view;
	ram_cmd_t          ram_cmd;
	logic [3:0]        bank_mod;
	logic [RAM_AW-1:0] ram_addr;
	logic [7:0]        ram_rdata;
	logic [1:0]        rd_sel;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_mode_q   <= 1'b0;
			rom_bank_mask_q <= 7'd1;
			ram_bank_mask_q <= 3'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAPPER_MODE:   mapper_mode_q   <= cfg_data[0];
				CFG_ROM_BANK_MASK: rom_bank_mask_q <= cfg_data;
				CFG_RAM_BANK_MASK: ram_bank_mask_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// flow control
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = clearing || (valid_s1 && !advance);
	assign accept   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			addr_s1 <= address;
			data_s1 <= data;
		end
	end

	cbc_bank_regs u_bank_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.op          (op_s1),
		.addr        (addr_s1),
		.wdata       (data_s1),
		.mapper_mode (mapper_mode_q),
		.rom_mask    (rom_bank_mask_q),
		.ram_mask    (ram_bank_mask_q),
		.view        (view)
	);

	// storage bank: effective bank folded into the banks present
	always_comb begin
		bank_mod = {1'b0, view.ram_bank};
		for (int i = 0; i < 8; i++) begin
			if (bank_mod >= 4'(MEM_BANK_COUNT)) begin
				bank_mod = bank_mod - 4'(MEM_BANK_COUNT);
			end
		end
	end

	assign ram_addr = RAM_AW'({bank_mod[2:0], addr_s1[RAM_OFS_W-1:0]});

	// ram access and read data source
	always_comb begin
		ram_cmd.wr = advance && view.ram_on && (op_s1 == OP_RAM_WR);
		ram_cmd.rd = advance && view.ram_on && (op_s1 == OP_RAM_RD);
		if (op_s1 == OP_RAM_RD) begin
			rd_sel = view.ram_on ? RD_MEM : RD_OFF;
		end else begin
			rd_sel = RD_ZERO;
		end
	end

	cbc_ram #(
		.DEPTH (RAM_DEPTH),
		.AW    (RAM_AW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ram_cmd),
		.addr   (ram_addr),
		.wdata  (data_s1),
		.rdata  (ram_rdata),
		.busy   (clearing)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rom_bank_s2 <= view.rom_bank;
			ram_bank_s2 <= view.ram_bank;
			ram_on_s2   <= view.ram_on;
			rd_sel_s2   <= rd_sel;
		end
	end

	// output mux
	always_comb begin
		case (rd_sel_s2)
			RD_MEM:  read_data = ram_rdata;
			RD_OFF:  read_data = RAM_OFF_BYTE;
			default: read_data = 8'h00;
		endcase
	end

	assign out_valid = valid_s2;
	assign rom_bank  = rom_bank_s2;
	assign ram_bank  = ram_bank_s2;
	assign ram_on    = ram_on_s2;

	// no transaction enters or sits in the pipe during the clearing pass
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (in_stall && !valid_s1 && !ram_cmd.wr))
		else $error("transaction during ram clearing pass");

	// a memory read result only comes with ram enabled
	a_mem_needs_on: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rd_sel_s2 == RD_MEM) |-> ram_on_s2)
		else $error("ram data returned while ram disabled");

	// shown banks stay within the configured masks
	a_bank_masked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (((rom_bank_s2 & ~rom_bank_mask_q) == 7'd0)
			&& ((ram_bank_s2 & ~ram_bank_mask_q) == 3'd0)))
		else $error("effective bank outside mask");

	// a stalled result keeps the ram read data it captured
	a_rdata_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> $stable(ram_rdata))
		else $error("ram read data changed under a stalled result");

endmodule

FILE: sv/cbc_bank_regs.sv
module cbc_bank_regs
	import cbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [1:0] op,
	input  logic [15:0] addr,
	input  logic [7:0] wdata,
	input  logic       mapper_mode,
	input  logic [6:0] rom_mask,
	input  logic [2:0] ram_mask,
	output bank_view_t view
);

	logic [6:0] rom_bank_q, rom_bank_n;
	logic [2:0] ram_bank_q, ram_bank_n;
	logic       ram_en_q, ram_en_n;
	logic       mode_q, mode_n;
	logic [6:0] lo_bank;

	// next register values for the transaction in flight
	always_comb begin
		rom_bank_n = rom_bank_q;
		ram_bank_n = ram_bank_q;
		ram_en_n   = ram_en_q;
		mode_n     = mode_q;
		lo_bank    = {rom_bank_q[6:5], wdata[4:0]};
		if (op == OP_CTRL_WR) begin
			unique case (addr[15:13])
				RGN_RAM_ENABLE: ram_en_n = (wdata[3:0] == RAM_ENABLE_KEY);
				RGN_BANK_LO: begin
					if (mapper_mode) begin
						rom_bank_n = (wdata[6:0] == 7'd0) ? ROM_BANK_RESET : wdata[6:0];
					end else begin
						// low five bits zero selects the next bank up
						rom_bank_n = {lo_bank[6:1], lo_bank[0] | (lo_bank[4:0] == 5'd0)};
					end
				end
				RGN_BANK_HI: begin
					if (mapper_mode) begin
						ram_bank_n = wdata[2:0];
					end else if (mode_q) begin
						ram_bank_n = {1'b0, wdata[1:0]};
					end else begin
						rom_bank_n = {wdata[1:0], rom_bank_q[4:0]};
					end
				end
				RGN_MODE_SEL: begin
					if (!mapper_mode) begin
						mode_n = wdata[0];
						if (wdata[0]) begin
							rom_bank_n = {2'b00, rom_bank_q[4:0]};
						end else begin
							ram_bank_n = 3'd0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// bank state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= ROM_BANK_RESET;
			ram_bank_q <= 3'd0;
			ram_en_q   <= 1'b0;
			mode_q     <= 1'b0;
		end else if (advance) begin
			rom_bank_q <= rom_bank_n;
			ram_bank_q <= ram_bank_n;
			ram_en_q   <= ram_en_n;
			mode_q     <= mode_n;
		end
	end

	// masked view after the update
	assign view.rom_bank = rom_bank_n & rom_mask;
	assign view.ram_bank = ram_bank_n & ram_mask;
	assign view.ram_on   = ram_en_n;

endmodule

FILE: sv/cbc_ram.sv
module cbc_ram
	import cbc_pkg::*;
#(
	parameter int unsigned DEPTH = 32768,
	parameter int unsigned AW    = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ram_cmd_t      cmd,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata,
	output logic          busy
);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic          clr_busy_q;
	logic [7:0]    rdata_q;

	// clearing pass after reset, one byte per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// storage array with registered read
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= 8'h00;
		end else if (cmd.wr) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule
